// ----- rtl/core/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, constants and byte-level functions for the aes block cipher
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] REG_MODE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY01 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY23 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY45 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_KEY67 = 3'd4;

  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;
  localparam logic [1:0] MODE_256 = 2'd2;

  // round counter width: up to 14 rounds
  localparam int unsigned RndW = 4;

  typedef logic [7:0] sbox_table_t [256];

  localparam sbox_table_t SBOX = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // control from the sequencer to the key schedule and the round unit
  typedef struct packed {
    logic load;      // start of a block: load key and state
    logic step;      // run one round
    logic last;      // the round being run is the final one (no mixcolumns)
  } aes_ctrl_t;

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

// ----- rtl/core/aes_key_sched.sv -----
// ----------------------------------------------------------------------------
// aes_key_sched
// on-the-fly key expansion: hands out one 128-bit round key per round
// ----------------------------------------------------------------------------
module aes_key_sched (
  input  logic              clk,
  input  logic              rst,
  input  aes_pkg::aes_ctrl_t ctrl,
  input  logic [1:0]        mode,
  input  logic [255:0]      key,
  output logic [127:0]      round_key
);
  import aes_pkg::*;

  // sliding window of the last nk schedule words in eight slots, w0 oldest
  logic [31:0] win [8];
  logic [31:0] win_next [8];
  logic [7:0]  rcon;
  logic [7:0]  rcon_next;
  // position of the next word within the nk-word cycle
  logic [2:0]  phase;
  logic [2:0]  phase_next;
  // the four schedule words that follow the nk words in the window
  logic [31:0] gen [4];
  // the four words that follow the oldest four
  logic [31:0] ahead [4];

  logic [31:0] t_in;
  logic [31:0] t_val;
  logic [2:0]  nk_m1;
  logic [2:0]  ph;
  logic [7:0]  rc;
  logic [3:0]  nk;
  logic [2:0]  ph_done;
  logic [7:0]  rc_done;
  logic [31:0] prev;

  always_comb begin
    unique case (mode)
      MODE_128: nk = 4'd4;
      MODE_192: nk = 4'd6;
      default:  nk = 4'd8;
    endcase
    nk_m1 = 3'(nk - 4'd1);
  end

  // the round key is the four schedule words that follow the oldest four in the window
  assign round_key = {ahead[0], ahead[1], ahead[2], ahead[3]};

  // generate four new words per round; nk-word recurrence over the window
  always_comb begin
    ph = phase;
    rc = rcon;
    prev = 32'h0;
    for (int j = 0; j < 4; j++) begin
      if (j == 0) begin
        prev = win[nk_m1];
      end else begin
        prev = gen[j-1];
      end
      t_in = prev;
      if (ph == 3'd0) begin
        t_val = sub_word({t_in[23:0], t_in[31:24]}) ^ {rc, 24'h0};
        rc = xtime(rc);
      end else if (nk == 4'd8 && ph == 3'd4) begin
        t_val = sub_word(t_in);
      end else begin
        t_val = t_in;
      end
      // w[i - nk] sits j places past the window start
      gen[j] = win[j] ^ t_val;
      ph = (ph == nk_m1) ? 3'd0 : 3'(ph + 3'd1);
    end
    ph_done = ph;
    rc_done = rc;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (4'(k + 4) < nk) begin
        ahead[k] = win[k + 4];
      end else begin
        ahead[k] = gen[2'(4'(k + 4) - nk)];
      end
    end
  end

  // load fills the window from the key; a step shifts it by four: words 4.. move down, generated words fill the top
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      win_next[k] = win[k];
    end
    phase_next = phase;
    rcon_next = rcon;
    if (ctrl.load) begin
      for (int k = 0; k < 8; k++) begin
        win_next[k] = key[255 - 32*k -: 32];
      end
      phase_next = 3'd0;
      rcon_next = 8'h01;
    end else if (ctrl.step) begin
      for (int k = 0; k < 4; k++) begin
        win_next[k] = ahead[k];
      end
      for (int k = 4; k < 8; k++) begin
        if (4'(k) < nk) begin
          win_next[k] = gen[2'(4'(k + 4) - nk)];
        end else begin
          win_next[k] = win[k];
        end
      end
      phase_next = ph_done;
      rcon_next = rc_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 3'd0;
      rcon <= 8'h01;
    end else begin
      phase <= phase_next;
      rcon <= rcon_next;
    end
    for (int k = 0; k < 8; k++) begin
      win[k] <= win_next[k];
    end
  end

endmodule

// ----- rtl/core/aes_round.sv -----
// ----------------------------------------------------------------------------
// aes_round
// shared round unit: subbytes, shiftrows, mixcolumns and addroundkey
// ----------------------------------------------------------------------------
module aes_round (
  input  logic              clk,
  input  aes_pkg::aes_ctrl_t ctrl,
  input  logic [127:0]      plain,
  input  logic [127:0]      round_key,
  output logic [127:0]      state
);
  import aes_pkg::*;

  logic [7:0]   s [16];
  logic [7:0]   t [16];
  logic [7:0]   m [16];
  logic [127:0] mixed;
  logic [127:0] state_next;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      s[k] = state[127 - 8*k -: 8];
    end
    // subbytes with shiftrows folded into the read index
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[r + 4*c] = SBOX[s[r + 4*((c + r) % 4)]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[4*c]   = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c+1] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
      m[4*c+2] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3]) ^ t[4*c+3];
      m[4*c+3] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xtime(t[4*c+3]);
    end
    for (int k = 0; k < 16; k++) begin
      mixed[127 - 8*k -: 8] = ctrl.last ? t[k] : m[k];
    end
    if (ctrl.load) begin
      state_next = plain ^ round_key;
    end else if (ctrl.step) begin
      state_next = mixed ^ round_key;
    end else begin
      state_next = state;
    end
  end

  always_ff @(posedge clk) begin
    state <= state_next;
  end

endmodule

// ----- rtl/core/aes_block_encrypt.sv -----
// ----------------------------------------------------------------------------
// aes_block_encrypt
// iterative aes-128/192/256 encryption core, one round per clock
// ----------------------------------------------------------------------------
// One 128-bit block per transaction. On acceptance the state is loaded and
// whitened with the first round key in that same cycle; after that the shared
// round unit runs one round per cycle, 10, 12 or 14 rounds for key mode 0, 1
// or 2 (mode 3 acts as mode 2). The state register doubles as the output
// register, so cipher valid rises once the last round is applied and holds
// until taken; the input is ready again the cycle after the result has been
// taken. Round keys are expanded on the fly, four words per round, from the
// key registers, which must only be written while the core is idle. Bytes
// are column-major, byte 0 in the top bits of the high half.
module aes_block_encrypt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [aes_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [aes_pkg::CfgDataW-1:0] cfg_data,
  input  logic                         valid_in,
  output logic                         ready_in,
  input  logic [63:0]                  plain_high,
  input  logic [63:0]                  plain_low,
  output logic                         valid_out,
  input  logic                         ready_out,
  output logic [63:0]                  cipher_high,
  output logic [63:0]                  cipher_low
);
  import aes_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t      st;
  logic [1:0]  key_length_mode;
  logic [63:0] key_regs [4];
  logic [RndW-1:0] rnd;
  logic [RndW-1:0] nr;
  logic [1:0]  mode_eff;
  aes_ctrl_t   ctrl;
  logic [127:0] round_key;
  logic [127:0] state_w;

  // mode three saturates to the 256-bit key size
  assign mode_eff = (key_length_mode == 2'd3) ? MODE_256 : key_length_mode;

  always_comb begin
    unique case (mode_eff)
      MODE_128: nr = 4'd10;
      MODE_192: nr = 4'd12;
      default:  nr = 4'd14;
    endcase
  end

  // configuration writes; out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length_mode <= MODE_128;
      for (int k = 0; k < 4; k++) begin
        key_regs[k] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  key_length_mode <= cfg_data[1:0];
        REG_KEY01: key_regs[0] <= cfg_data;
        REG_KEY23: key_regs[1] <= cfg_data;
        REG_KEY45: key_regs[2] <= cfg_data;
        REG_KEY67: key_regs[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ready_in  = (st == ST_IDLE);
  assign valid_out = (st == ST_DONE);

  always_comb begin
    ctrl.load = valid_in && ready_in;
    ctrl.step = (st == ST_RUN);
    ctrl.last = (rnd == nr);
  end

  // sequencer: rnd counts the round now being applied
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      rnd <= 4'd1;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (valid_in) begin
            st <= ST_RUN;
            rnd <= 4'd1;
          end
        end
        ST_RUN: begin
          if (rnd == nr) begin
            st <= ST_DONE;
          end
          rnd <= rnd + 4'd1;
        end
        ST_DONE: begin
          if (ready_out) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  aes_key_sched u_key (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .mode      (mode_eff),
    .key       ({key_regs[0], key_regs[1], key_regs[2], key_regs[3]}),
    .round_key (round_key)
  );

  aes_round u_round (
    .clk       (clk),
    .ctrl      (ctrl),
    .plain     ({plain_high, plain_low}),
    .round_key (ctrl.load ? {key_regs[0], key_regs[1]} : round_key),
    .state     (state_w)
  );

  // state register holds the result until the transaction completes
  assign cipher_high = state_w[127:64];
  assign cipher_low  = state_w[63:0];

endmodule

// ----- test/aes_block_encrypt_tb.sv -----
// ----------------------------------------------------------------------------
// aes_block_encrypt_tb
// self-checking bench for the iterative aes encryption core: a directed table
// of known-answer blocks and key-mode corners, then random blocks under
// random keys and modes, each result checked against its known answer or an in-bench aes model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes_block_encrypt_tb;
  import aes_pkg::*;

  localparam int unsigned NumRandom = 450;
  localparam int unsigned PhaseLen = 75;     // random blocks per key setting
  localparam int unsigned DrainCycles = 20;  // outlasts a block in the slowest mode
  localparam int unsigned WatchLimit = 3000;
  localparam int unsigned HoldCycles = 300;

  typedef logic [7:0] blk_t [16];

  // one directed transaction, optionally preceded by a new key setting
  typedef struct {
    bit           set_cfg;
    logic [1:0]   mode;
    logic [63:0]  key [4];
    logic [127:0] plain;
    bit           known;
    logic [127:0] cipher;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                valid_in = 1'b0;
  logic                ready_in;
  logic [63:0]         plain_high = '0;
  logic [63:0]         plain_low = '0;
  logic                valid_out;
  logic                ready_out = 1'b0;
  logic [63:0]         cipher_high;
  logic [63:0]         cipher_low;

  // shadow of the key registers as the core should see them
  logic [1:0]   key_mode = MODE_128;
  logic [63:0]  key_shadow [4] = '{default: '0};

  logic [127:0] cipher_q [$];   // expected ciphertexts, oldest first
  logic [7:0]   sbox_tab [256];
  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  burst_left = 0;
  bit           hold_req = 1'b0;

  dir_row_t dir_rows [$];

  aes_block_encrypt uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .valid_in   (valid_in),
    .ready_in   (ready_in),
    .plain_high (plain_high),
    .plain_low  (plain_low),
    .valid_out  (valid_out),
    .ready_out  (ready_out),
    .cipher_high(cipher_high),
    .cipher_low (cipher_low)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b = b >> 1;
    end
    return r;
  endfunction

  // multiplicative inverse as x^254, then the affine map
  function automatic logic [7:0] sbox_calc(logic [7:0] x);
    logic [7:0] r, p;
    int unsigned e;
    r = 8'h01;
    p = x;
    e = 254;
    while (e != 0) begin
      if (e[0]) r = gf_mul(r, p);
      p = gf_mul(p, p);
      e = e >> 1;
    end
    return r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^ {r[3:0], r[7:4]} ^ 8'h63;
  endfunction

  function automatic logic [31:0] sub_w(logic [31:0] w);
    return {sbox_tab[w[31:24]], sbox_tab[w[23:16]], sbox_tab[w[15:8]], sbox_tab[w[7:0]]};
  endfunction

  function automatic blk_t add_key(blk_t s, logic [31:0] w0, logic [31:0] w1,
                                   logic [31:0] w2, logic [31:0] w3);
    logic [127:0] rk;
    rk = {w0, w1, w2, w3};
    for (int b = 0; b < 16; b++) s[b] ^= rk[127-8*b -: 8];
    return s;
  endfunction

  // subbytes and shiftrows together; byte b is row b%4, column b/4
  function automatic blk_t sub_shift(blk_t s);
    blk_t t;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) t[r+4*c] = sbox_tab[s[r+4*((c+r)%4)]];
    return t;
  endfunction

  function automatic blk_t mix_cols(blk_t s);
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
      s[4*c]   = gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3;
      s[4*c+1] = a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3;
      s[4*c+2] = a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03);
      s[4*c+3] = gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02);
    end
    return s;
  endfunction

  function automatic logic [127:0] aes_cipher(logic [1:0] mode, logic [63:0] key [4],
                                              logic [127:0] plain);
    logic [31:0]  w [60];
    logic [31:0]  t;
    logic [7:0]   rcon;
    logic [127:0] res;
    blk_t         s;
    int           nk, nr;
    nk = (mode == MODE_128) ? 4 : (mode == MODE_192) ? 6 : 8;  // mode 3 saturates
    nr = nk + 6;
    rcon = 8'h01;
    for (int i = 0; i < 8; i++) w[i] = i[0] ? key[i/2][31:0] : key[i/2][63:32];
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      t = w[i-1];
      if (i % nk == 0) begin
        t = sub_w({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
        rcon = gf_mul(rcon, 8'h02);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_w(t);
      end
      w[i] = w[i-nk] ^ t;
    end
    for (int b = 0; b < 16; b++) s[b] = plain[127-8*b -: 8];
    s = add_key(s, w[0], w[1], w[2], w[3]);
    for (int r = 1; r < nr; r++) begin
      s = add_key(mix_cols(sub_shift(s)), w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]);
    end
    s = add_key(sub_shift(s), w[4*nr], w[4*nr+1], w[4*nr+2], w[4*nr+3]);
    for (int b = 0; b < 16; b++) res[127-8*b -: 8] = s[b];
    return res;
  endfunction

  // ---------------------------------------------------------------- helpers

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // wait until every result is back, then let the core settle
  task automatic wait_idle();
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // write the whole key setting; out-of-range indexes must be ignored
  task automatic load_key(logic [1:0] mode, logic [63:0] key [4]);
    logic [CfgIdxW-1:0] idx;
    cfg_we <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data <= {$urandom, $urandom} & ~64'h3 | mode;  // upper bits must not matter
    @(posedge clk);
    key_mode = (mode == 2'd3) ? MODE_256 : mode;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= REG_KEY01 + CfgIdxW'(i);
      cfg_data <= key[i];
      @(posedge clk);
      key_shadow[i] = key[i];
    end
    // junk writes past the last register
    for (int i = REG_KEY67 + 1; i < (1 << CfgIdxW); i++) begin
      idx = CfgIdxW'(i);
      cfg_index <= idx;
      cfg_data <= {$urandom, $urandom};
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // offer one block; the sender runs in bursts with random gaps between them
  task automatic send_block(logic [127:0] plain, bit known, logic [127:0] cipher);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        valid_in <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    valid_in <= 1'b1;
    plain_high <= plain[127:64];
    plain_low <= plain[63:0];
    do @(posedge clk); while (!ready_in);
    // transaction accepted at this edge
    cipher_q.push_back(known ? cipher : aes_cipher(key_mode, key_shadow, plain));
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic dir_row_t mk_row(bit set_cfg, logic [1:0] mode, logic [63:0] k0,
                                      logic [63:0] k1, logic [63:0] k2, logic [63:0] k3,
                                      logic [127:0] plain, bit known, logic [127:0] cipher);
    dir_row_t r;
    r.set_cfg = set_cfg; r.mode = mode;
    r.key[0] = k0; r.key[1] = k1; r.key[2] = k2; r.key[3] = k3;
    r.plain = plain; r.known = known; r.cipher = cipher;
    return r;
  endfunction

  // ---------------------------------------------------------------- checker

  // compare each delivered ciphertext with the oldest expectation
  always @(posedge clk) begin
    if (!rst && valid_out && ready_out) begin
      if (cipher_q.size() == 0) begin
        report("unexpected cipher_high", cipher_high, 64'h0);
      end else begin
        if (cipher_high !== cipher_q[0][127:64])
          report("cipher_high", cipher_high, cipher_q[0][127:64]);
        if (cipher_low !== cipher_q[0][63:0])
          report("cipher_low", cipher_low, cipher_q[0][63:0]);
        void'(cipher_q.pop_front());
      end
    end
  end

  // watchdog: too long with no transaction on either side ends the run
  always @(posedge clk) begin
    if ((valid_in && ready_in) || (valid_out && ready_out) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchLimit) begin
      $display("aes_block_encrypt_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- receiver

  // stretches of always-ready, random stalls and a periodic pattern; on
  // request one long hold-off so the core fills up and blocks its input
  initial begin
    int unsigned len, kind, per;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        ready_out <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      len = $urandom_range(10, 80);
      kind = $urandom_range(0, 2);
      per = $urandom_range(2, 5);
      for (int i = 0; i < len; i++) begin
        case (kind)
          0: ready_out <= 1'b1;
          1: ready_out <= ($urandom_range(0, 2) != 0);
          default: ready_out <= (i % per != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    logic [63:0]  key [4];
    logic [127:0] plain;
    logic [1:0]   mode;
    dir_row_t     row;

    for (int i = 0; i < 256; i++) sbox_tab[i] = sbox_calc(8'(i));

    // known answers from the standard appendix; unused key words hold junk
    dir_rows.push_back(mk_row(0, MODE_128, '0, '0, '0, '0, '0,
                              1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e));
    dir_rows.push_back(mk_row(0, MODE_128, '0, '0, '0, '0, '1, 0, '0));
    dir_rows.push_back(mk_row(1, MODE_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                              '1, '1, 128'h00112233445566778899aabbccddeeff,
                              1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a));
    dir_rows.push_back(mk_row(0, MODE_128, '0, '0, '0, '0, '0, 0, '0));
    dir_rows.push_back(mk_row(0, MODE_128, '0, '0, '0, '0, '1, 0, '0));
    dir_rows.push_back(mk_row(1, MODE_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                              64'h1011121314151617, '1,
                              128'h00112233445566778899aabbccddeeff,
                              1, 128'hdda97ca4864cdfe06eaf70a0ec0d7191));
    dir_rows.push_back(mk_row(0, MODE_192, '0, '0, '0, '0, '1, 0, '0));
    dir_rows.push_back(mk_row(1, MODE_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                              64'h1011121314151617, 64'h18191a1b1c1d1e1f,
                              128'h00112233445566778899aabbccddeeff,
                              1, 128'h8ea2b7ca516745bfeafc49904b496089));
    // mode three saturates to the 256-bit key
    dir_rows.push_back(mk_row(1, 2'd3, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                              64'h1011121314151617, 64'h18191a1b1c1d1e1f,
                              128'h00112233445566778899aabbccddeeff,
                              1, 128'h8ea2b7ca516745bfeafc49904b496089));
    dir_rows.push_back(mk_row(0, MODE_256, '0, '0, '0, '0, '0, 0, '0));
    dir_rows.push_back(mk_row(1, MODE_256, '1, '1, '1, '1, '1, 0, '0));
    dir_rows.push_back(mk_row(0, MODE_256, '0, '0, '0, '0, '0, 0, '0));
    dir_rows.push_back(mk_row(1, MODE_192, '1, '1, '1, '0, {8{16'ha55a}}, 0, '0));
    dir_rows.push_back(mk_row(1, MODE_128, '1, '1, '0, '0, {8{16'h5aa5}}, 0, '0));
    dir_rows.push_back(mk_row(0, MODE_128, '0, '0, '0, '0, '1, 0, '0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.set_cfg) begin
        valid_in <= 1'b0;
        burst_left = 0;
        wait_idle();
        load_key(row.mode, row.key);
      end
      send_block(row.plain, row.known, row.cipher);
    end

    // random part: a fresh key setting every phase, mode three included
    for (int n = 0; n < NumRandom; n++) begin
      if (n % PhaseLen == 0) begin
        valid_in <= 1'b0;
        burst_left = 0;
        wait_idle();
        mode = 2'($urandom_range(0, 3));
        for (int i = 0; i < 4; i++) key[i] = rand_word();
        load_key(mode, key);
      end
      if (n == 100) hold_req = 1'b1;
      case ($urandom_range(0, 9))
        0: plain = '0;
        1: plain = '1;
        default: plain = {$urandom, $urandom, $urandom, $urandom};
      endcase
      send_block(plain, 0, '0);
    end
    valid_in <= 1'b0;

    wait_idle();
    if (mismatch_count == 0 && cipher_q.size() == 0) begin
      $display("aes_block_encrypt_tb passed");
    end else begin
      $display("aes_block_encrypt_tb failed");
    end
    $finish;
  end

endmodule
